// File: sv/maf_pkg.sv
// Shared constants, command/status types and controller states of the moving average filter.
`timescale 1ns / 1ps

package maf_pkg;

  // Deepest window the sample ring can hold
  localparam int WINDOW_MAX = 256;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 9;
  localparam int PTR_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W    = SAMPLE_W + PTR_W + 1;
  // Magnitude of the running sum, the dividend of the divider
  localparam int QUO_W    = SUM_W - 1;
  localparam int STEP_W   = $clog2(QUO_W);
  localparam int CMP_W    = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Register map, word index taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = LEN_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_DONE
  } maf_state_e;

  typedef struct packed {
    logic load_item;
    logic clear_win;
    logic update;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: sv/maf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module maf_ram #(
  parameter int Width = 16,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/maf_ctrl.sv
// Controller state machine: sequences ring read, sum update and the division steps.
`timescale 1ns / 1ps

module maf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_clear_i,
  output logic                   in_ready_o,
  input  maf_pkg::dp_status_t    status_i,
  output maf_pkg::ctrl_cmd_t     cmd_o
);

  maf_pkg::maf_state_e           state_q, state_d;
  logic [maf_pkg::STEP_W-1:0]    cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= maf_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      maf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_clear_i) begin
            cmd_o.clear_win = 1'b1;
          end else begin
            cmd_o.load_item = 1'b1;
            state_d         = maf_pkg::ST_UPDATE;
          end
        end
      end
      maf_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = maf_pkg::ST_LOAD;
      end
      maf_pkg::ST_LOAD: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = maf_pkg::STEP_W'(maf_pkg::QUO_W - 1);
        state_d        = maf_pkg::ST_DIVIDE;
      end
      maf_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = maf_pkg::ST_DONE;
        end
      end
      maf_pkg::ST_DONE: begin
        // hold the quotient until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = maf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = maf_pkg::ST_IDLE;
      end
    endcase
  end

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == maf_pkg::ST_DIVIDE && cnt_q == '0) |=> state_q == maf_pkg::ST_DONE)
    else $error("division did not end after its last step");

  a_sample_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> (state_q == maf_pkg::ST_UPDATE && !in_ready_o))
    else $error("accepted sample did not start an update");

endmodule

// File: sv/maf_dp.sv
// Datapath: sample ring, running sum, fill count, restoring divider and output register.
`timescale 1ns / 1ps

module maf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  maf_pkg::ctrl_cmd_t                cmd_i,
  output maf_pkg::dp_status_t               status_o,
  input  logic [maf_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic [maf_pkg::CNT_W-1:0]         eff_len_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [maf_pkg::SAMPLE_W-1:0]      out_data_o
);

  localparam int SW = maf_pkg::SAMPLE_W;
  localparam int MW = maf_pkg::SUM_W;
  localparam int CW = maf_pkg::CNT_W;
  localparam int PW = maf_pkg::PTR_W;
  localparam int QW = maf_pkg::QUO_W;

  // window state
  logic [MW-1:0] sum_q, sum_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          drop_q;
  logic [SW-1:0] sample_q;

  // divider
  logic [QW-1:0] quo_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] div_q;
  logic          neg_q;

  // output register
  logic          out_valid_q;
  logic [SW-1:0] mean_q;

  logic [SW-1:0] ring_rdata;
  logic [PW-1:0] ring_raddr;
  logic [CW:0]   oldest_raw;
  logic [CW:0]   oldest_wrap;
  logic [MW-1:0] old_ext;
  logic [MW-1:0] new_ext;
  logic [MW-1:0] sum_neg;
  logic [QW-1:0] sum_mag;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_diff;
  logic          quo_bit;
  logic [CW-1:0] rem_next;
  logic [SW-1:0] mean_d;

  // oldest slot = write pointer minus fill count, modulo the ring depth
  always_comb begin
    oldest_raw  = (CW + 1)'(wp_q) + (CW + 1)'(maf_pkg::WINDOW_MAX) - (CW + 1)'(fill_q);
    oldest_wrap = oldest_raw;
    if (oldest_raw >= (CW + 1)'(maf_pkg::WINDOW_MAX)) begin
      oldest_wrap = oldest_raw - (CW + 1)'(maf_pkg::WINDOW_MAX);
    end
    ring_raddr = oldest_wrap[PW-1:0];
  end

  maf_ram #(
    .Width (SW),
    .Depth (maf_pkg::WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (wp_q),
    .wdata_i (sample_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    old_ext = drop_q ? {{(MW - SW){ring_rdata[SW-1]}}, ring_rdata} : '0;
    new_ext = {{(MW - SW){sample_q[SW-1]}}, sample_q};
    sum_d   = sum_q - old_ext + new_ext;
    wp_d    = (wp_q == PW'(maf_pkg::WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
    // drop one, add one: fill stays put once the window is full
    fill_d  = drop_q ? fill_q : fill_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      wp_q   <= '0;
      fill_q <= '0;
      drop_q <= 1'b0;
    end else begin
      if (cmd_i.clear_win) begin
        sum_q  <= '0;
        wp_q   <= '0;
        fill_q <= '0;
      end else if (cmd_i.update) begin
        sum_q  <= sum_d;
        wp_q   <= wp_d;
        fill_q <= fill_d;
      end
      if (cmd_i.load_item) begin
        drop_q <= (fill_q >= eff_len_i);
      end
    end
  end

  // restoring division, one quotient bit per step
  always_comb begin
    sum_neg  = -sum_q;
    sum_mag  = sum_q[MW-1] ? sum_neg[QW-1:0] : sum_q[QW-1:0];
    rem_sh   = {rem_q, quo_q[QW-1]};
    rem_diff = rem_sh - {1'b0, div_q};
    quo_bit  = ~rem_diff[CW];
    rem_next = quo_bit ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
    mean_d   = neg_q ? (~quo_q[SW-1:0] + 1'b1) : quo_q[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sample_q <= sample_i;
    end
    if (cmd_i.div_init) begin
      quo_q <= sum_mag;
      rem_q <= '0;
      div_q <= fill_q;
      neg_q <= sum_q[MW-1];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[QW-2:0], quo_bit};
      rem_q <= rem_next;
    end
    if (cmd_i.out_load) begin
      mean_q <= mean_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = mean_q;
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (fill_q != '0 && fill_q <= CW'(maf_pkg::WINDOW_MAX)))
    else $error("fill count out of range after update");

  a_wp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q <= PW'(maf_pkg::WINDOW_MAX - 1)))
    else $error("write pointer beyond ring depth");

endmodule

// File: sv/moving_average_filter_core.sv
// Top level of the moving average filter: stream ports, APB register and block wiring.
`timescale 1ns / 1ps

// Boxcar mean over the most recent window_length signed 16-bit samples. A sample
// beat (tuser = 0) adds the sample to a running sum, first dropping the oldest held
// sample once the window is full, and returns the sum divided by the number of held
// samples, truncated toward zero; the first results after reset or a clear therefore
// average fewer samples. A clear beat (tuser = 1) empties the window and gives no
// result. From acceptance to its result standing in the output register, a sample
// passes these steps: the oldest sample is read from the ring RAM at the accepting
// edge itself, then sum and ring are updated, the divider is loaded, the restoring
// divider yields one quotient bit per cycle, and the result register is written; the
// next beat is taken in the cycle after, so the block takes no new sample until it
// is through with the last. The result register holds a finished mean while the
// next sample is accepted; a new mean waits, and the input stays stalled, for as long
// as the previous one has not been taken.
// window_length sits at byte address 0 (9 bits, reset 16); zero acts as one and
// values above 256 act as 256. Shortening the window while it is full drops one
// old sample per beat but adds one too, so the held count stays put. Write the
// register only while the block is idle. The ring needs no clearing pass after reset.

module moving_average_filter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // slave stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // [15:0] sample
  input  logic [0:0]                 s_axis_tuser,   // [0] clear
  // master stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,   // [15:0] mean
  // APB register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [maf_pkg::APB_AW-1:0] paddr,
  input  logic [maf_pkg::APB_DW-1:0] pwdata,
  output logic [maf_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  logic [maf_pkg::LEN_W-1:0] wlen_q;
  logic [maf_pkg::CMP_W-1:0] wlen_ext;
  logic [maf_pkg::CMP_W-1:0] eff_ext;
  logic [maf_pkg::CNT_W-1:0] eff_len;
  logic                      reg_sel;

  maf_pkg::ctrl_cmd_t        cmd;
  maf_pkg::dp_status_t       status;

  // Register write on the access phase; pready is tied high
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == maf_pkg::REG_WINDOW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= maf_pkg::WINDOW_LENGTH_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      wlen_q <= pwdata[maf_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = maf_pkg::APB_DW'(wlen_q);
    end
  end

  // Clamp the window length to the range the ring supports
  always_comb begin
    wlen_ext = maf_pkg::CMP_W'(wlen_q);
    eff_ext  = wlen_ext;
    if (wlen_ext == '0) begin
      eff_ext = maf_pkg::CMP_W'(1);
    end else if (wlen_ext > maf_pkg::CMP_W'(maf_pkg::WINDOW_MAX)) begin
      eff_ext = maf_pkg::CMP_W'(maf_pkg::WINDOW_MAX);
    end
    eff_len = eff_ext[maf_pkg::CNT_W-1:0];
  end

  maf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_clear_i (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  maf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata),
    .eff_len_i   (eff_len),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
